### rtl/mskf_pkg.sv
// ----------------------------------------------------------------------------
// mskf_pkg
// Shared widths, constants and types for the multichannel scalar Kalman core.
// ----------------------------------------------------------------------------
package mskf_pkg;

    // Channel and sample geometry
    localparam int CHANNELS    = 8;
    localparam int CH_BITS     = 3;
    localparam int IDX_BITS    = $clog2(CHANNELS);
    localparam int SAMPLE_BITS = 12;
    localparam int EST_BITS    = SAMPLE_BITS + 8;

    // Configuration register widths
    localparam int Q_BITS      = 24;
    localparam int R_BITS      = 32;
    localparam int THR_BITS    = 12;
    localparam int CFG_BITS    = 32;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [Q_BITS-1:0]   Q_RESET   = Q_BITS'(1678);
    localparam logic [R_BITS-1:0]   R_RESET   = R_BITS'(83886080);
    localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(20);

    // Covariance, gain and divider widths (Q8.24 covariance, Q1.24 gain)
    localparam int COV_BITS  = 32;
    localparam int DEN_BITS  = COV_BITS + 1;
    localparam int REM_BITS  = DEN_BITS + 1;
    localparam int FRAC_BITS = 24;
    localparam int GAIN_BITS = FRAC_BITS + 1;
    localparam int CNT_BITS  = $clog2(GAIN_BITS);
    localparam logic [GAIN_BITS-1:0] GAIN_ONE = GAIN_BITS'(1) << FRAC_BITS;

    // Shared multiplier
    localparam int MUL_A_BITS = 32;
    localparam int MUL_B_BITS = GAIN_BITS;
    localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;

    // Blend weights, Q0.16, summing to one
    localparam int W_BITS     = 16;
    localparam logic [MUL_B_BITS-1:0] W_NEW = MUL_B_BITS'(25035);
    localparam logic [MUL_B_BITS-1:0] W_OLD = MUL_B_BITS'(40501);
    localparam int BLEND_BITS = EST_BITS + W_BITS;
    localparam int CORR_BITS  = GAIN_BITS + EST_BITS;

    // Jump test compare width
    localparam int CMP_BITS = (EST_BITS > THR_BITS + 8) ? EST_BITS : THR_BITS + 8;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_PROCESS_NOISE  = 2'd0,
        CFG_MEASURE_NOISE  = 2'd1,
        CFG_JUMP_THRESHOLD = 2'd2
    } t_cfg_idx;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_JUMP,
        S_BL0,
        S_BL1,
        S_BL2,
        S_DIV,
        S_CORR,
        S_COV,
        S_WB
    } t_state;

    // Shared multiplier operand selection
    typedef enum logic [1:0] {
        MUL_BLEND_NEW,
        MUL_BLEND_OLD,
        MUL_CORR,
        MUL_COV
    } t_mul_sel;

endpackage

### rtl/mskf_div.sv
// ----------------------------------------------------------------------------
// mskf_div
// Restoring divider for the Kalman gain: floor(num * 2^24 / den), one
// quotient bit per cycle. A zero divisor yields a zero quotient at once.
// ----------------------------------------------------------------------------
module mskf_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [mskf_pkg::COV_BITS-1:0]   i_num,
    input  logic [mskf_pkg::DEN_BITS-1:0]   i_den,
    output logic                            o_busy,
    output logic [mskf_pkg::GAIN_BITS-1:0]  o_quot
);
    import mskf_pkg::*;

    logic                 r_busy;
    logic [CNT_BITS-1:0]  r_cnt;
    logic [DEN_BITS-1:0]  r_den;
    logic [REM_BITS-1:0]  r_rem;
    logic [GAIN_BITS-1:0] r_quot;

    logic                 ge;
    logic [REM_BITS-1:0]  rem_nx;

    // Trial subtract of the divisor from the partial remainder
    always_comb begin
        ge     = (r_rem >= {1'b0, r_den});
        rem_nx = ge ? (r_rem - {1'b0, r_den}) : r_rem;
    end

    // Busy flag: hold over the quotient bits, drop after the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= (i_den != '0);
        end else if (r_busy && (r_cnt == '0)) begin
            r_busy <= 1'b0;
        end
    end

    // Datapath: load operands, then shift in one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den  <= i_den;
            r_rem  <= REM_BITS'(i_num);
            r_quot <= '0;
            r_cnt  <= CNT_BITS'(GAIN_BITS - 1);
        end else if (r_busy) begin
            r_quot <= {r_quot[GAIN_BITS-2:0], ge};
            r_rem  <= {rem_nx[REM_BITS-2:0], 1'b0};
            r_cnt  <= r_cnt - 1'b1;
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

### rtl/multichannel_scalar_kalman_filter_core.sv
// ----------------------------------------------------------------------------
// multichannel_scalar_kalman_filter_core
// Eight-channel scalar Kalman filter for converter samples. One shared
// multiplier and a bit-serial divider run under a small sequencer.
// ----------------------------------------------------------------------------
// Each accepted word runs load, jump test, optional jump blend, the 25-step
// gain divider (passed at once on a zero denominator), correction, covariance
// update and write-back. The input stalls while a word is in work; a finished
// result sits in an output register, and the sequencer waits only on a busy
// divider or a full, stalled output register. Synchronous active-low reset
// clears all channel estimates and covariances and loads the defaults.
// ----------------------------------------------------------------------------
module multichannel_scalar_kalman_filter_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [mskf_pkg::CH_BITS-1:0]      i_channel,
    input  logic [mskf_pkg::SAMPLE_BITS-1:0]  i_sample,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [mskf_pkg::EST_BITS-1:0]     o_estimate,
    output logic [mskf_pkg::CH_BITS-1:0]      o_channel_out,
    // configuration port
    input  logic                              i_cfg_we,
    input  logic [mskf_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [mskf_pkg::CFG_BITS-1:0]     i_cfg_data
);
    import mskf_pkg::*;

    // Configuration registers
    logic [Q_BITS-1:0]   r_q;
    logic [R_BITS-1:0]   r_r;
    logic [THR_BITS-1:0] r_thr;

    // Channel state
    logic [EST_BITS-1:0] r_est_store [CHANNELS];
    logic [COV_BITS-1:0] r_cov_store [CHANNELS];

    // Sequencer and working registers
    t_state                r_state, n_state;
    logic [CH_BITS-1:0]    r_ch;
    logic [EST_BITS-1:0]   r_s;
    logic [EST_BITS-1:0]   r_x;
    logic [EST_BITS-1:0]   r_xm;
    logic [EST_BITS-1:0]   r_xn;
    logic [COV_BITS-1:0]   r_pm;
    logic [BLEND_BITS-1:0] r_acc;
    logic [PROD_BITS-1:0]  r_prod;
    logic                  r_sge;
    logic                  r_oor;

    // Output register
    logic                  r_out_valid;
    logic [EST_BITS-1:0]   r_out_est;
    logic [CH_BITS-1:0]    r_out_ch;

    // Combinational
    logic                  in_acc;
    logic                  out_free;
    logic                  ch_ok;
    logic [IDX_BITS-1:0]   idx;
    logic [COV_BITS:0]     pm_sum;
    logic [COV_BITS-1:0]   pm_sat;
    logic [EST_BITS-1:0]   diff;
    logic                  jump;
    logic [DEN_BITS-1:0]   den;
    logic [BLEND_BITS-1:0] blend_sum;
    logic [EST_BITS-1:0]   mag;
    logic [CORR_BITS-1:0]  corr_sum;
    logic [EST_BITS-1:0]   corr;
    logic [COV_BITS-1:0]   pn;
    t_mul_sel              mul_sel;
    logic [MUL_A_BITS-1:0] mul_a;
    logic [MUL_B_BITS-1:0] mul_b;
    logic [PROD_BITS-1:0]  mul_p;
    logic                  div_start;
    logic                  div_busy;
    logic [GAIN_BITS-1:0]  kg;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign ch_ok    = (int'(r_ch) < CHANNELS);
    assign idx      = r_ch[IDX_BITS-1:0];

    // Predicted covariance, saturated to the store width
    always_comb begin
        pm_sum = {1'b0, r_cov_store[idx]} + (COV_BITS + 1)'(r_q);
        pm_sat = pm_sum[COV_BITS] ? '1 : pm_sum[COV_BITS-1:0];
    end

    // Jump test and gain denominator
    always_comb begin
        diff = (r_x >= r_s) ? (r_x - r_s) : (r_s - r_x);
        jump = (CMP_BITS'(diff) >= CMP_BITS'({r_thr, 8'd0}));
        den  = {1'b0, r_pm} + DEN_BITS'(r_r);
    end

    // Blend rounding, correction magnitude, rounding and new covariance
    always_comb begin
        blend_sum = r_acc + r_prod[BLEND_BITS-1:0] + BLEND_BITS'(1 << (W_BITS - 1));
        mag       = (r_s >= r_xm) ? (r_s - r_xm) : (r_xm - r_s);
        corr_sum  = r_prod[CORR_BITS-1:0] + CORR_BITS'(1 << (FRAC_BITS - 1));
        corr      = corr_sum[FRAC_BITS +: EST_BITS];
        pn        = r_prod[FRAC_BITS +: COV_BITS];
    end

    // Shared multiplier
    always_comb begin
        case (mul_sel)
            MUL_BLEND_NEW: begin
                mul_a = MUL_A_BITS'(r_s);
                mul_b = W_NEW;
            end
            MUL_BLEND_OLD: begin
                mul_a = MUL_A_BITS'(r_x);
                mul_b = W_OLD;
            end
            MUL_CORR: begin
                mul_a = MUL_A_BITS'(mag);
                mul_b = kg;
            end
            default: begin
                mul_a = MUL_A_BITS'(r_pm);
                mul_b = GAIN_ONE - kg;
            end
        endcase
        mul_p = {{MUL_B_BITS{1'b0}}, mul_a} * {{MUL_A_BITS{1'b0}}, mul_b};
    end

    // Gain divider
    mskf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_pm),
        .i_den   (den),
        .o_busy  (div_busy),
        .o_quot  (kg)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_acc) n_state = S_LOAD;
            S_LOAD: n_state = ch_ok ? S_JUMP : S_WB;
            S_JUMP: n_state = jump ? S_BL0 : S_DIV;
            S_BL0:  n_state = S_BL1;
            S_BL1:  n_state = S_BL2;
            S_BL2:  n_state = S_DIV;
            S_DIV:  if (!div_busy) n_state = S_CORR;
            S_CORR: n_state = S_COV;
            S_COV:  n_state = S_WB;
            S_WB:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        div_start  = (r_state == S_JUMP);
        unique case (r_state)
            S_BL0:   mul_sel = MUL_BLEND_NEW;
            S_BL1:   mul_sel = MUL_BLEND_OLD;
            S_CORR:  mul_sel = MUL_CORR;
            default: mul_sel = MUL_COV;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q   <= Q_RESET;
            r_r   <= R_RESET;
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PROCESS_NOISE:  r_q   <= i_cfg_data[Q_BITS-1:0];
                CFG_MEASURE_NOISE:  r_r   <= i_cfg_data[R_BITS-1:0];
                CFG_JUMP_THRESHOLD: r_thr <= i_cfg_data[THR_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Working datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_ch <= i_channel;
                    r_s  <= {i_sample, 8'd0};
                end
            end
            S_LOAD: begin
                r_oor <= !ch_ok;
                r_x   <= r_est_store[idx];
                r_xm  <= r_est_store[idx];
                r_pm  <= pm_sat;
            end
            S_BL0: begin
                r_prod <= mul_p;
            end
            S_BL1: begin
                r_acc  <= r_prod[BLEND_BITS-1:0];
                r_prod <= mul_p;
            end
            S_BL2: begin
                r_xm <= blend_sum[W_BITS +: EST_BITS];
            end
            S_CORR: begin
                r_sge  <= (r_s >= r_xm);
                r_prod <= mul_p;
            end
            S_COV: begin
                r_xn   <= r_sge ? (r_xm + corr) : (r_xm - corr);
                r_prod <= mul_p;
            end
            default: ;
        endcase
    end

    // Channel store: clear at reset, write back the finished update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_est_store[i] <= '0;
                r_cov_store[i] <= '0;
            end
        end else if ((r_state == S_WB) && out_free && !r_oor) begin
            r_est_store[idx] <= r_xn;
            r_cov_store[idx] <= pn;
        end
    end

    // Output register: load the finished word, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_WB) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_WB) && out_free) begin
            r_out_est <= r_oor ? '0 : r_xn;
            r_out_ch  <= r_ch;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_estimate    = r_out_est;
    assign o_channel_out = r_out_ch;

endmodule
